>>> rtl/core/qs3w_pkg.sv
// qs3w_pkg: shared types and sequencer codes for the three-way quicksort block.
// No dependencies; used by quicksort_three_way.
package qs3w_pkg;

  typedef logic [3:0] state_t;

  localparam state_t S_LOAD  = 4'd0;   // take elements from the input channel
  localparam state_t S_POP   = 4'd1;   // read the top of the range stack
  localparam state_t S_PIV0  = 4'd2;   // range bounds arrive, fetch pivot
  localparam state_t S_PIV1  = 4'd3;   // pivot value arrives
  localparam state_t S_RD    = 4'd4;   // fetch scan and greater-bound entries
  localparam state_t S_CMP   = 4'd5;   // compare against pivot, first write
  localparam state_t S_WR2   = 4'd6;   // second write of a swap
  localparam state_t S_PUSH1 = 4'd7;   // push the less-than range
  localparam state_t S_PUSH2 = 4'd8;   // push the greater-than range
  localparam state_t S_ORD   = 4'd9;   // fetch next sorted element
  localparam state_t S_OSHOW = 4'd10;  // present a result transaction

endpackage

>>> rtl/core/quicksort_three_way.sv
// quicksort_three_way: loads a set of signed values, sorts them in place and streams them out.
// Depends on qs3w_pkg for the sequencer state codes.
//
// Usage:
//  - Input channel (in_valid/in_ready, in_value, in_last): one element per transaction.
//    Elements land in the element memory as they are accepted. Elements beyond MAX_COUNT are
//    dropped and mark the whole run with out_overflow. The transaction with in_last set
//    closes the set and starts sorting; in_ready stays low until the last result leaves.
//  - Sort: quicksort with three-way partitioning around the first element of each range,
//    ranges kept on a small stack memory. The element memory has one write port and two
//    registered read ports, so a partition step that finds an entry equal to the pivot
//    passes through fetch and compare only, while a swap adds a second write state (two
//    writes through the single write port). Each range adds stack and pivot traffic.
//  - Result channel (out_valid/out_ready, out_sorted_value, out_last_out, out_overflow):
//    one transaction per stored element in ascending order, each read from memory (registered
//    read, then present) only after the previous one is taken. out_last_out marks the final one.
//  - A stalled receiver simply holds the current result; the sequencer waits.
//  - Reset (rst_n low, synchronous) empties the set; memories are not cleared, since
//    every entry is written before it is read.
module quicksort_three_way #(
  parameter int MAX_COUNT  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_sorted_value,
  output logic                         out_last_out,
  output logic                         out_overflow
);

  // Index into the element store, count that can also hold MAX_COUNT.
  localparam int IDX_W = $clog2(MAX_COUNT);
  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  // Pending ranges are disjoint and hold two or more entries each.
  localparam int STK_DEPTH = MAX_COUNT / 2;
  localparam int SA_W      = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
  localparam int SP_W      = $clog2(STK_DEPTH + 1);
  localparam int ENT_W     = 2 * IDX_W;

  // Control registers.
  qs3w_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  // Partition registers.
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] lt_r, lt_nxt;
  logic [IDX_W-1:0] gt_r, gt_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] outk_r, outk_nxt;
  logic [DATA_WIDTH-1:0] piv_r, piv_nxt;
  logic [IDX_W-1:0]      pend_addr_r, pend_addr_nxt;
  logic [DATA_WIDTH-1:0] pend_data_r, pend_data_nxt;

  // Element memory: one write port, two registered read ports.
  logic [DATA_WIDTH-1:0] elem_mem [MAX_COUNT];
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  rda_en, rdb_en;
  logic [IDX_W-1:0]      rda_addr, rdb_addr;
  logic [DATA_WIDTH-1:0] rda_r, rdb_r;

  // Range stack memory: {lo, hi} per entry.
  logic [ENT_W-1:0] stk_mem [STK_DEPTH];
  logic             stk_we, stk_re;
  logic [SA_W-1:0]  stk_waddr, stk_raddr;
  logic [ENT_W-1:0] stk_wdata, stk_rd_r;

  logic             in_acc, out_acc, last_res;
  logic [CNT_W-1:0] n_load;
  logic             piv_less, piv_greater;
  logic             push_lo, push_hi;

  assign in_ready  = (state_r == qs3w_pkg::S_LOAD);
  assign out_valid = (state_r == qs3w_pkg::S_OSHOW);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign out_sorted_value = $signed(rda_r);
  assign last_res         = ((CNT_W'(outk_r) + CNT_W'(1)) == cnt_r);
  assign out_last_out     = last_res;
  assign out_overflow     = drop_r;

  // Element count once the current input transaction is stored (or dropped).
  assign n_load = (cnt_r < CNT_W'(MAX_COUNT)) ? (cnt_r + CNT_W'(1)) : cnt_r;

  // Signed order on the raw bits matches the flipped-sign unsigned order.
  assign piv_less    = $signed(rda_r) < $signed(piv_r);
  assign piv_greater = $signed(rda_r) > $signed(piv_r);

  // Sub-ranges that still need sorting after a partition.
  assign push_lo = CNT_W'(lt_r) > (CNT_W'(lo_r) + CNT_W'(1));
  assign push_hi = (CNT_W'(gt_r) + CNT_W'(1)) < CNT_W'(hi_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lt_nxt        = lt_r;
    gt_nxt        = gt_r;
    scan_nxt      = scan_r;
    outk_nxt      = outk_r;
    piv_nxt       = piv_r;
    pend_addr_nxt = pend_addr_r;
    pend_data_nxt = pend_data_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = pend_data_r;
    rda_en        = 1'b0;
    rda_addr      = outk_r;
    rdb_en        = 1'b0;
    rdb_addr      = gt_r;
    stk_we        = 1'b0;
    stk_waddr     = SA_W'(sp_r);
    stk_wdata     = {lo_r, hi_r};
    stk_re        = 1'b0;
    stk_raddr     = SA_W'(sp_r - SP_W'(1));

    unique case (state_r)
      qs3w_pkg::S_LOAD: begin
        if (in_acc) begin
          // Store while there is room, else drop and flag the run.
          if (cnt_r < CNT_W'(MAX_COUNT)) begin
            mem_we    = 1'b1;
            mem_waddr = IDX_W'(cnt_r);
            mem_wdata = in_value;
          end else begin
            drop_nxt = 1'b1;
          end
          cnt_nxt = n_load;
          if (in_last) begin
            outk_nxt = '0;
            if (n_load < CNT_W'(2)) begin
              state_nxt = qs3w_pkg::S_ORD;
            end else begin
              // Seed the stack with the whole set.
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = {IDX_W'(0), IDX_W'(n_load - CNT_W'(1))};
              sp_nxt    = SP_W'(1);
              state_nxt = qs3w_pkg::S_POP;
            end
          end
        end
      end
      qs3w_pkg::S_POP: begin
        if (sp_r == '0) begin
          outk_nxt  = '0;
          state_nxt = qs3w_pkg::S_ORD;
        end else begin
          stk_re    = 1'b1;
          sp_nxt    = sp_r - SP_W'(1);
          state_nxt = qs3w_pkg::S_PIV0;
        end
      end
      qs3w_pkg::S_PIV0: begin
        lo_nxt    = stk_rd_r[ENT_W-1:IDX_W];
        hi_nxt    = stk_rd_r[IDX_W-1:0];
        lt_nxt    = stk_rd_r[ENT_W-1:IDX_W];
        gt_nxt    = stk_rd_r[IDX_W-1:0];
        scan_nxt  = CNT_W'(stk_rd_r[ENT_W-1:IDX_W]);
        rda_en    = 1'b1;
        rda_addr  = stk_rd_r[ENT_W-1:IDX_W];
        state_nxt = qs3w_pkg::S_PIV1;
      end
      qs3w_pkg::S_PIV1: begin
        piv_nxt   = rda_r;
        state_nxt = qs3w_pkg::S_RD;
      end
      qs3w_pkg::S_RD: begin
        if (scan_r > CNT_W'(gt_r)) begin
          state_nxt = qs3w_pkg::S_PUSH1;
        end else begin
          rda_en    = 1'b1;
          rda_addr  = IDX_W'(scan_r);
          rdb_en    = 1'b1;
          rdb_addr  = gt_r;
          state_nxt = qs3w_pkg::S_CMP;
        end
      end
      qs3w_pkg::S_CMP: begin
        if (piv_less) begin
          // Entry at lt equals the pivot: move scan value down, pivot up.
          mem_we        = 1'b1;
          mem_waddr     = lt_r;
          mem_wdata     = rda_r;
          pend_addr_nxt = IDX_W'(scan_r);
          pend_data_nxt = piv_r;
          lt_nxt        = lt_r + IDX_W'(1);
          scan_nxt      = scan_r + CNT_W'(1);
          state_nxt     = qs3w_pkg::S_WR2;
        end else if (piv_greater) begin
          // Swap with the greater bound; scan index holds.
          mem_we        = 1'b1;
          mem_waddr     = gt_r;
          mem_wdata     = rda_r;
          pend_addr_nxt = IDX_W'(scan_r);
          pend_data_nxt = rdb_r;
          gt_nxt        = gt_r - IDX_W'(1);
          state_nxt     = qs3w_pkg::S_WR2;
        end else begin
          scan_nxt  = scan_r + CNT_W'(1);
          state_nxt = qs3w_pkg::S_RD;
        end
      end
      qs3w_pkg::S_WR2: begin
        mem_we    = 1'b1;
        state_nxt = qs3w_pkg::S_RD;
      end
      qs3w_pkg::S_PUSH1: begin
        if (push_lo) begin
          stk_we    = 1'b1;
          stk_wdata = {lo_r, lt_r - IDX_W'(1)};
          sp_nxt    = sp_r + SP_W'(1);
        end
        state_nxt = qs3w_pkg::S_PUSH2;
      end
      qs3w_pkg::S_PUSH2: begin
        if (push_hi) begin
          stk_we    = 1'b1;
          stk_wdata = {gt_r + IDX_W'(1), hi_r};
          sp_nxt    = sp_r + SP_W'(1);
        end
        state_nxt = qs3w_pkg::S_POP;
      end
      qs3w_pkg::S_ORD: begin
        rda_en    = 1'b1;
        rda_addr  = outk_r;
        state_nxt = qs3w_pkg::S_OSHOW;
      end
      qs3w_pkg::S_OSHOW: begin
        if (out_acc) begin
          if (last_res) begin
            // Run complete: empty the set for the next one.
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = qs3w_pkg::S_LOAD;
          end else begin
            outk_nxt  = outk_r + IDX_W'(1);
            state_nxt = qs3w_pkg::S_ORD;
          end
        end
      end
      default: begin
        state_nxt = qs3w_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qs3w_pkg::S_LOAD;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      sp_r    <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      lt_r    <= '0;
      gt_r    <= '0;
      scan_r  <= '0;
      outk_r  <= '0;
      piv_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      sp_r    <= sp_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      lt_r    <= lt_nxt;
      gt_r    <= gt_nxt;
      scan_r  <= scan_nxt;
      outk_r  <= outk_nxt;
      piv_r   <= piv_nxt;
    end
  end

  // Pending second write of a swap.
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
  end

  // Element memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rda_en) begin
      rda_r <= elem_mem[rda_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rdb_en) begin
      rdb_r <= elem_mem[rdb_addr];
    end
  end

  // Range stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_raddr];
    end
  end

  // Loading and result delivery never overlap.
  a_no_load_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels open at once");

  // The range stack never grows past its depth.
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STK_DEPTH))
    else $error("range stack overrun");

  // A compare only follows a fetch inside the unscanned window.
  a_scan_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qs3w_pkg::S_CMP) |-> (scan_r <= CNT_W'(gt_r)))
    else $error("scan index past greater bound");

  // The final result empties the set and clears the overflow mark.
  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_out) |=> (cnt_r == '0 && !drop_r && in_ready))
    else $error("set not emptied after final result");

endmodule
